>>> src/xtea_block_cipher_assert.svh
// Assertion helpers shared by the output queue and the top-level cipher module.
// Both sample on clk and are off while rst_n is low.
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Property checked at every rising clock edge.
`define XT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define XT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/xtea_pkg.sv
package xtea_pkg;

  localparam int unsigned XT_WORD_W     = 32;
  localparam int unsigned XT_KEY_N      = 4;
  localparam int unsigned XT_SEL_W      = 2;
  localparam int unsigned XT_KEY_SHIFT  = 11;
  localparam int unsigned XT_ROUNDS_DEF = 32;
  localparam logic [XT_WORD_W-1:0] XT_DELTA = 32'h9E37_79B9;

  typedef logic [XT_WORD_W-1:0] word_t;
  typedef logic [XT_KEY_N-1:0][XT_WORD_W-1:0] key_t;
  typedef logic [XT_SEL_W-1:0] sel_t;

  // one block in flight
  typedef struct packed {
    logic  op;  // 0 encrypt, 1 decrypt
    word_t x;
    word_t y;
  } xt_beat_t;

  // delta * n, mod 2^32 (elaboration only)
  function automatic word_t xt_sum(input int unsigned n);
    logic [2*XT_WORD_W-1:0] p;
    p = {{XT_WORD_W{1'b0}}, XT_DELTA} * (2*XT_WORD_W)'(n);
    return p[XT_WORD_W-1:0];
  endfunction

endpackage

>>> src/xtea_half.sv
module xtea_half import xtea_pkg::*; #(
  parameter int unsigned ROUNDS = XT_ROUNDS_DEF,
  parameter int unsigned STAGE  = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  key_t     key,
  input  logic     v_i,
  input  xt_beat_t b_i,
  output logic     v_o,
  output xt_beat_t b_o
);

  localparam int unsigned RND  = STAGE / 2;
  localparam int unsigned HALF = STAGE % 2;
  localparam word_t SUM_E = xt_sum(RND + HALF);
  localparam word_t SUM_D = xt_sum(ROUNDS - RND - HALF);
  localparam sel_t  SEL_E = (HALF != 0) ? SUM_E[XT_KEY_SHIFT+1:XT_KEY_SHIFT] : SUM_E[1:0];
  localparam sel_t  SEL_D = (HALF != 0) ? SUM_D[1:0] : SUM_D[XT_KEY_SHIFT+1:XT_KEY_SHIFT];
  localparam logic  HALF_B = (HALF != 0);

  logic     v_r;
  xt_beat_t b_r;
  logic     upd_x;
  word_t    src, dst, f, t, m, dst_new;
  xt_beat_t b_nxt;

  // encrypt: x on first half, y on second; decrypt the other way round
  always_comb begin
    upd_x   = ~(b_i.op ^ HALF_B);
    src     = upd_x ? b_i.y : b_i.x;
    dst     = upd_x ? b_i.x : b_i.y;
    f       = ((src << 4) ^ (src >> 5)) + src;
    t       = b_i.op ? (SUM_D + key[SEL_D]) : (SUM_E + key[SEL_E]);
    m       = f ^ t;
    dst_new = b_i.op ? (dst - m) : (dst + m);
    b_nxt   = b_i;
    if (upd_x) begin
      b_nxt.x = dst_new;
    end else begin
      b_nxt.y = dst_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= b_nxt;
    end
  end

  assign v_o = v_r;
  assign b_o = b_r;

endmodule

>>> src/xtea_outq.sv
`include "xtea_block_cipher_assert.svh"

module xtea_outq import xtea_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  word_t push_x,
  input  word_t push_y,
  output logic  full,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_x,
  output word_t out_y
);

  logic [1:0] cnt_r, cnt_nxt, cnt_left;
  word_t      hx_r, hy_r, sx_r, sy_r;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_comb begin
    cnt_left = cnt_r - {1'b0, pop};
    cnt_nxt  = cnt_left + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head feeds the port, second slot catches a beat while head waits
  always_ff @(posedge clk) begin
    if (pop && full) begin
      hx_r <= sx_r;
      hy_r <= sy_r;
    end
    if (push) begin
      if (cnt_left == 2'd0) begin
        hx_r <= push_x;
        hy_r <= push_y;
      end else begin
        sx_r <= push_x;
        sy_r <= push_y;
      end
    end
  end

  assign out_x = hx_r;
  assign out_y = hy_r;

  `XT_ASSERT(a_cnt_range, cnt_r != 2'd3, "output queue count out of range")
  `XT_ASSERT(a_no_push_full, push |-> !full, "push into full output queue")

endmodule

>>> src/xtea_block_cipher.sv
// XTEA block cipher, 64-bit block, 128-bit key, fully unrolled pipeline.
//
// Key: four 32-bit words written through cfg_wr_en / cfg_index / cfg_wdata,
// one word per clock, no wait. Write them only while no block is in flight.
// Input channel (in_valid / in_ready): one block per beat, two 32-bit
// halves plus the direction bit (0 encrypt, 1 decrypt). Blocks are
// independent (ECB); each one yields exactly one result beat on the
// out_valid / out_ready channel, in order.
// Path: an accepted block passes one pipeline register per half-round,
// then the output queue, which drives out_valid.
// Throughput: one beat per cycle, sustained while out_ready stays high.
// Stall: a two-beat output queue absorbs results; when it is full and the
// last stage holds a result, the whole pipeline freezes and in_ready drops.
// Nothing in flight is lost or repeated.
// Reset (rst_n low, synchronous): pipeline and queue empty, key words zero.

`include "xtea_block_cipher_assert.svh"

module xtea_block_cipher import xtea_pkg::*; #(
  parameter int unsigned ROUNDS = XT_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // key write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input blocks
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_block_word0,
  input  logic [31:0] in_block_word1,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_word0,
  output logic [31:0] out_result_word1
);

  localparam int unsigned NSTG = 2 * ROUNDS;

  key_t     key_r;
  logic     advance;
  logic     q_full;
  logic     push;
  logic     stg_v [0:NSTG];
  xt_beat_t stg_b [0:NSTG];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // stage 0 input is the port itself; all stages move together
  assign stg_v[0]    = in_valid;
  assign stg_b[0].op = in_operation;
  assign stg_b[0].x  = in_block_word0;
  assign stg_b[0].y  = in_block_word1;

  // freeze only when a finished block has nowhere to go
  assign advance  = !stg_v[NSTG] || !q_full;
  assign in_ready = advance;
  assign push     = stg_v[NSTG] && advance;

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    xtea_half #(
      .ROUNDS (ROUNDS),
      .STAGE  (g)
    ) u_half (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .key   (key_r),
      .v_i   (stg_v[g]),
      .b_i   (stg_b[g]),
      .v_o   (stg_v[g+1]),
      .b_o   (stg_b[g+1])
    );
  end

  xtea_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_x    (stg_b[NSTG].x),
    .push_y    (stg_b[NSTG].y),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_result_word0),
    .out_y     (out_result_word1)
  );

  // a stall always has a waiting block behind it, and that block holds still
  `XT_ASSERT(a_stall_cause, !in_ready |-> (stg_v[NSTG] && q_full), "stall without cause")
  `XT_ASSERT_NEXT(a_stall_hold, !in_ready, stg_v[NSTG] && $stable(stg_b[NSTG]), "stalled block moved")

endmodule

>>> sim/tb_xtea_block_cipher.sv
module tb_xtea_block_cipher;
  import xtea_pkg::*;

  // Timing and run-size knobs
  localparam int unsigned ROUNDS         = XT_ROUNDS_DEF;
  localparam int unsigned TAIL_CYCLES    = 2 * ROUNDS + 8;    // pipeline depth plus slack
  localparam int unsigned WATCHDOG_LIMIT = 20 * 2 * ROUNDS;   // quiet cycles before giving up
  localparam int unsigned RANDOM_BLOCKS  = 800;
  localparam int unsigned MAX_REPORTS    = 50;

  typedef enum logic {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} xt_op_e;
  typedef enum logic [1:0] {KEY_WORD0, KEY_WORD1, KEY_WORD2, KEY_WORD3} key_reg_e;

  // One block as sent, plus the transformed block the cipher must return
  typedef struct {
    xt_op_e op;
    word_t  src0;
    word_t  src1;
    word_t  res0;
    word_t  res1;
  } cipher_block_t;

  // DUT ports; every input has a known value from time zero
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [1:0]  cfg_index      = '0;
  logic [31:0] cfg_wdata      = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_operation   = 1'b0;
  logic [31:0] in_block_word0 = '0;
  logic [31:0] in_block_word1 = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] out_result_word0;
  logic [31:0] out_result_word1;

  // Scoreboard state
  word_t         cipher_key [XT_KEY_N] = '{default: '0};  // mirror of the key registers
  cipher_block_t cipher_results_q [$];                    // transformed blocks still owed
  cipher_block_t last_block;
  bit            have_last_block = 1'b0;

  // Idle controls; cleared for the back-to-back stretch
  bit          sender_gaps_en = 1'b1;
  bit          sink_stalls_en = 1'b1;
  int unsigned stall_left     = 0;

  // Bookkeeping
  int unsigned mismatches      = 0;
  int unsigned blocks_sent     = 0;
  int unsigned encrypt_blocks  = 0;
  int unsigned decrypt_blocks  = 0;
  int unsigned results_checked = 0;
  int unsigned keys_loaded     = 0;
  int unsigned quiet_cycles    = 0;

  xtea_block_cipher DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_block_word0   (in_block_word0),
    .in_block_word1   (in_block_word1),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word0 (out_result_word0),
    .out_result_word1 (out_result_word1)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: XTEA round function and the full 32-round transform
  // ---------------------------------------------------------------------------
  function automatic word_t feistel_mix(word_t v, word_t s, word_t k);
    return (((v << 4) ^ (v >> 5)) + v) ^ (s + k);
  endfunction

  function automatic cipher_block_t xtea_transform(xt_op_e op, word_t w0, word_t w1);
    cipher_block_t blk;
    word_t         x;
    word_t         y;
    word_t         sum;
    int            r;
    x = w0;
    y = w1;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (r = 0; r < ROUNDS; r++) begin
        x   += feistel_mix(y, sum, cipher_key[sum[XT_SEL_W-1:0]]);
        sum += XT_DELTA;
        y   += feistel_mix(x, sum, cipher_key[sum[XT_KEY_SHIFT +: XT_SEL_W]]);
      end
    end else begin
      // decrypt runs the schedule backwards from delta * rounds (mod 2^32)
      sum = XT_DELTA * word_t'(ROUNDS);
      for (r = 0; r < ROUNDS; r++) begin
        y   -= feistel_mix(x, sum, cipher_key[sum[XT_KEY_SHIFT +: XT_SEL_W]]);
        sum -= XT_DELTA;
        x   -= feistel_mix(y, sum, cipher_key[sum[XT_SEL_W-1:0]]);
      end
    end
    blk.op   = op;
    blk.src0 = w0;
    blk.src1 = w1;
    blk.res0 = x;
    blk.res1 = y;
    return blk;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly zero or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Block words biased toward the corners
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, 31);
      3: return ~(word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_key_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Key register writes (only while nothing is in flight)
  // ---------------------------------------------------------------------------
  task automatic write_key_word(key_reg_e idx, word_t value);
    @(negedge clk);
    cfg_wr_en       = 1'b1;
    cfg_index       = idx;
    cfg_wdata       = value;
    cipher_key[idx] = value;
  endtask

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_key_word(KEY_WORD0, k0);
    write_key_word(KEY_WORD1, k1);
    write_key_word(KEY_WORD2, k2);
    write_key_word(KEY_WORD3, k3);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    keys_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, then a random gap
  // ---------------------------------------------------------------------------
  task automatic send_block(xt_op_e op, word_t w0, word_t w1);
    int unsigned gap;
    @(negedge clk);
    in_valid       = 1'b1;
    in_operation   = op;
    in_block_word0 = w0;
    in_block_word1 = w1;
    do @(posedge clk); while (!in_ready);
    // accepted on this edge; the key cannot change while it is in flight
    last_block      = xtea_transform(op, w0, w1);
    have_last_block = 1'b1;
    cipher_results_q.push_back(last_block);
    blocks_sent++;
    if (op == OP_ENCRYPT) encrypt_blocks++;
    else decrypt_blocks++;
    gap = sender_gaps_en ? gap_len() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and let every owed result come back before touching the key
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (cipher_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure on out_ready
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (sink_stalls_en) stall_left = gap_len();
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Result checker: each accepted beat against the oldest owed block
  always @(posedge clk) begin
    cipher_block_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_results_q.size() == 0) begin
        report_mismatch($sformatf("result beat %08h_%08h with nothing owed",
                                  out_result_word0, out_result_word1));
      end else begin
        want = cipher_results_q.pop_front();
        results_checked++;
        if (out_result_word0 !== want.res0)
          report_mismatch($sformatf("result_word0 %08h, want %08h (%s %08h_%08h)",
                                    out_result_word0, want.res0, want.op.name(),
                                    want.src0, want.src1));
        if (out_result_word1 !== want.res1)
          report_mismatch($sformatf("result_word1 %08h, want %08h (%s %08h_%08h)",
                                    out_result_word1, want.res1, want.op.name(),
                                    want.src0, want.src1));
      end
    end
  end

  // Watchdog: too long with no beat on either channel means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: %0d cycles with no beat, %0d results outstanding",
               quiet_cycles, cipher_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Key straight out of reset is all zero; no writes before these blocks
  task automatic test_reset_key();
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    wait_drained();
  endtask

  // Corner keys and corner blocks, plus encrypt/decrypt round trips both ways
  task automatic test_corner_blocks();
    load_key('1, '1, '1, '1);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    wait_drained();

    load_key(32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    // ciphertext fed back must decrypt to the plaintext
    send_block(OP_DECRYPT, last_block.res0, last_block.res1);
    send_block(OP_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210);
    send_block(OP_ENCRYPT, last_block.res0, last_block.res1);
    wait_drained();
  endtask

  // Back-to-back beats on both sides: no gaps, no new stalls once any current one ends
  task automatic test_full_rate();
    int i;
    load_key(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
    sender_gaps_en = 1'b0;
    sink_stalls_en = 1'b0;
    for (i = 0; i < 100; i++)
      send_block(xt_op_e'($urandom_range(0, 1)), pick_word(), pick_word());
    wait_drained();
    sender_gaps_en = 1'b1;
    sink_stalls_en = 1'b1;
  endtask

  // Random blocks in phases, a fresh key per phase, random idling throughout
  task automatic test_random_blocks();
    int unsigned target;
    int unsigned phase_len;
    int          i;
    target = blocks_sent + RANDOM_BLOCKS - 100;
    while (blocks_sent < target) begin
      if ($urandom_range(0, 5) == 0)
        load_key('0, '1, '0, '1);
      else
        load_key(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
      phase_len = $urandom_range(60, 140);
      for (i = 0; i < phase_len && blocks_sent < target; i++) begin
        // now and then reverse the last block to close the loop
        if (have_last_block && $urandom_range(0, 4) == 0)
          send_block(last_block.op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT,
                     last_block.res0, last_block.res1);
        else
          send_block(xt_op_e'($urandom_range(0, 1)), pick_word(), pick_word());
      end
      wait_drained();
      have_last_block = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_key();
    test_corner_blocks();
    test_full_rate();
    test_random_blocks();

    // all owed results are in; watch a pipeline's worth more for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d blocks (%0d encrypt, %0d decrypt) under %0d loaded keys",
             blocks_sent, encrypt_blocks, decrypt_blocks, keys_loaded);
    $display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/xtea_pkg.sv
src/xtea_half.sv
src/xtea_outq.sv
src/xtea_block_cipher.sv
sim/tb_xtea_block_cipher.sv
